// ===== rtl/kcr_pkg.sv =====
package kcr_pkg;

  // Store geometry.
  localparam int MaxNodes = 64;
  localparam int AddrW    = $clog2(MaxNodes);
  localparam int CntW     = $clog2(MaxNodes + 1);

  // Result status codes.
  localparam logic [2:0] StInterp = 3'd0;
  localparam logic [2:0] StClamp  = 3'd1;
  localparam logic [2:0] StEmpty  = 3'd2;
  localparam logic [2:0] StInsert = 3'd3;
  localparam logic [2:0] StFull   = 3'd4;

  // One stored node: key and coordinates, all signed Q16.16.
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } entry_t;

  // Twice a tangent, the exact difference of two coordinates.
  typedef logic signed [32:0] diff_t;

  // Select one coordinate of a node by axis.
  function automatic logic signed [31:0] crd(input entry_t e, input logic [1:0] a);
    logic signed [31:0] r;
    case (a)
      2'd0:    r = e.x;
      2'd1:    r = e.y;
      default: r = e.z;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/kcr_mem.sv =====
module kcr_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [kcr_pkg::AddrW-1:0]    waddr_i,
  input  kcr_pkg::entry_t              wdata_i,
  input  logic [kcr_pkg::AddrW-1:0]    raddr_i,
  output kcr_pkg::entry_t              rdata_o
);
  import kcr_pkg::*;

  entry_t mem_q [MaxNodes];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/kcr_div.sv =====
module kcr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [15:0] q_o
);
  import kcr_pkg::*;

  logic [31:0] rem_q;
  logic [31:0] den_q;
  logic [15:0] q_q;
  logic [4:0]  cnt_q;
  logic [32:0] shl;
  logic [32:0] sub;
  logic        ge;

  // Restoring division, one quotient bit per cycle. The numerator is
  // below the divisor, so the remainder always fits in 32 bits.
  assign shl = {rem_q, 1'b0};
  assign sub = shl - {1'b0, den_q};
  assign ge  = shl >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else if (start_i) begin
      cnt_q <= 5'd16;
    end else if (cnt_q != 5'd0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      q_q   <= 16'd0;
    end else if (cnt_q != 5'd0) begin
      rem_q <= ge ? sub[31:0] : shl[31:0];
      q_q   <= {q_q[14:0], ge};
    end
  end

  assign busy_o = cnt_q != 5'd0;
  assign q_o    = q_q;

endmodule

// ===== rtl/kcr_eval.sv =====
module kcr_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [15:0]                   t_i,
  input  kcr_pkg::entry_t               p1_i,
  input  kcr_pkg::entry_t               p2_i,
  input  kcr_pkg::diff_t [2:0]          m1_i,
  input  kcr_pkg::diff_t [2:0]          m2_i,
  output logic                          done_o,
  output logic signed [31:0]            res_x_o,
  output logic signed [31:0]            res_y_o,
  output logic signed [31:0]            res_z_o
);
  import kcr_pkg::*;

  typedef enum logic [6:0] {
    E_IDLE  = 7'b0000001,
    E_SQ    = 7'b0000010,
    E_CUBE  = 7'b0000100,
    E_BASIS = 7'b0001000,
    E_MUL   = 7'b0010000,
    E_ACC   = 7'b0100000,
    E_DONE  = 7'b1000000
  } est_e;

  est_e state_q, state_d;

  logic [15:0]        t_q;
  logic [31:0]        t2_q;
  logic [47:0]        t3_q;
  logic signed [27:0] h_q [4];
  logic [1:0]         ax_q, term_q;
  logic signed [61:0] prod_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] res_q [3];

  logic signed [51:0] t1s, t2s, t3s, one;
  logic signed [33:0] v_sel;
  logic signed [31:0] c_sel;
  logic signed [63:0] acc_n, rnd;

  // Round half up at 24 fraction bits of a 48 bit fraction.
  function automatic logic signed [27:0] rnd24(input logic signed [51:0] v);
    logic signed [51:0] s;
    s = (v + 52'sd8388608) >>> 24;
    return s[27:0];
  endfunction

  // Saturate to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Powers of t aligned to 48 fraction bits.
  assign t1s = $signed({4'b0, t_q, 32'b0});
  assign t2s = $signed({4'b0, t2_q, 16'b0});
  assign t3s = $signed({4'b0, t3_q});
  assign one = 52'sd1 <<< 48;

  // Operand for the current term: doubled points, doubled tangents.
  always_comb begin
    c_sel = 32'sd0;
    case (term_q)
      2'd0: begin
        c_sel = crd(p1_i, ax_q);
        v_sel = $signed({c_sel[31], c_sel, 1'b0});
      end
      2'd1: begin
        c_sel = crd(p2_i, ax_q);
        v_sel = $signed({c_sel[31], c_sel, 1'b0});
      end
      2'd2:    v_sel = $signed({m1_i[ax_q][32], m1_i[ax_q]});
      default: v_sel = $signed({m2_i[ax_q][32], m2_i[ax_q]});
    endcase
  end

  // Accumulate the registered product and round the finished sum.
  assign acc_n = ((term_q == 2'd0) ? 64'sd0 : acc_q) + {{2{prod_q[61]}}, prod_q};
  assign rnd   = (acc_n + 64'sd16777216) >>> 25;

  always_comb begin
    state_d = state_q;
    case (state_q)
      E_IDLE:  if (start_i) state_d = E_SQ;
      E_SQ:    state_d = E_CUBE;
      E_CUBE:  state_d = E_BASIS;
      E_BASIS: state_d = E_MUL;
      E_MUL:   state_d = E_ACC;
      E_ACC:   state_d = (term_q == 2'd3 && ax_q == 2'd2) ? E_DONE : E_MUL;
      E_DONE:  state_d = E_IDLE;
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: one multiply per state, every product registered.
  always_ff @(posedge clk_i) begin
    case (state_q)
      E_IDLE: begin
        t_q    <= t_i;
        ax_q   <= 2'd0;
        term_q <= 2'd0;
      end
      E_SQ:   t2_q <= t_q * t_q;
      E_CUBE: t3_q <= 48'(t2_q) * 48'(t_q);
      E_BASIS: begin
        h_q[0] <= rnd24((t3s <<< 1) - (t2s + (t2s <<< 1)) + one);
        h_q[1] <= rnd24((t2s + (t2s <<< 1)) - (t3s <<< 1));
        h_q[2] <= rnd24(t3s - (t2s <<< 1) + t1s);
        h_q[3] <= rnd24(t3s - t2s);
      end
      E_MUL: prod_q <= h_q[term_q] * v_sel;
      E_ACC: begin
        acc_q  <= acc_n;
        term_q <= term_q + 2'd1;
        if (term_q == 2'd3) begin
          res_q[ax_q] <= sat32(rnd);
          ax_q        <= ax_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign done_o  = state_q == E_DONE;
  assign res_x_o = res_q[0];
  assign res_y_o = res_q[1];
  assign res_z_o = res_q[2];

endmodule

// ===== rtl/keyed_catmull_rom_interpolator.sv =====
// Insert and empty-store query: the accepted request goes to the emit state, and the
// result is registered once the output is free. Query: a key scan over the single memory
// read port (a key outside the nodes clamps to an end node), a fetch of the neighbor
// nodes while the divide for t runs, the Hermite evaluation and a register for the result.
// One item is in work at a time; the next is taken only once the result is emitted.
// Reset clears the node count and control state; the node memory is not cleared.
module keyed_catmull_rom_interpolator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] node_x_i,
  input  logic signed [31:0] node_y_i,
  input  logic signed [31:0] node_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [5:0]         segment_o,
  output logic [2:0]         status_o
);
  import kcr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_FETCH = 6'b000100,
    S_TAN   = 6'b001000,
    S_EVAL  = 6'b010000,
    S_EMIT  = 6'b100000
  } st_e;

  // Fetch slots for the segment neighborhood and the path ends.
  localparam logic [2:0] SlPrev  = 3'd0;
  localparam logic [2:0] SlCur   = 3'd1;
  localparam logic [2:0] SlNext  = 3'd2;
  localparam logic [2:0] SlNext2 = 3'd3;
  localparam logic [2:0] SlFirst = 3'd4;
  localparam logic [2:0] SlSec   = 3'd5;
  localparam logic [2:0] SlPen   = 3'd6;
  localparam logic [2:0] SlLast  = 3'd7;

  st_e state_q, state_d;

  logic [CntW-1:0]    count_q;
  logic signed [31:0] key_q, prev_key_q;
  logic [AddrW-1:0]   scan_q, seg_q;
  logic [3:0]         fetch_q;
  entry_t             slot_q [8];
  diff_t [2:0]        m1_q, m2_q;
  logic               out_valid_q;
  logic signed [31:0] res_x_q, res_y_q, res_z_q;
  logic [5:0]         res_seg_q;
  logic [2:0]         res_st_q;

  logic               in_acc, out_free;
  logic               mem_we;
  entry_t             wdata, rdata;
  logic [AddrW-1:0]   raddr, faddr;
  logic signed [32:0] num_w, den_w;
  logic               found, at_last, closed, first_seg, last_seg;
  logic               div_busy, ev_done, div_start, ev_start;
  logic [15:0]        t_w;
  logic signed [31:0] ev_x, ev_y, ev_z;
  diff_t [2:0]        m1_d, m2_d;

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Scan compare of the query key against the current segment.
  assign num_w   = $signed({key_q[31], key_q}) - $signed({prev_key_q[31], prev_key_q});
  assign den_w   = $signed({rdata.key[31], rdata.key}) - $signed({prev_key_q[31], prev_key_q});
  assign found   = (scan_q != '0) && (key_q >= prev_key_q) && (key_q < rdata.key);
  assign at_last = {1'b0, scan_q} == count_q - CntW'(1);

  assign div_start = (state_q == S_SCAN) && found;
  assign ev_start  = (state_q == S_TAN) && !div_busy;

  // Node write on an accepted insert transaction while the store is not full.
  assign mem_we    = in_acc && !req_type_i && (count_q < CntW'(MaxNodes));
  assign wdata.key = key_i;
  assign wdata.x   = node_x_i;
  assign wdata.y   = node_y_i;
  assign wdata.z   = node_z_i;

  // Neighborhood fetch addresses.
  always_comb begin
    case (fetch_q[2:0])
      SlPrev:  faddr = seg_q - AddrW'(1);
      SlCur:   faddr = seg_q;
      SlNext:  faddr = seg_q + AddrW'(1);
      SlNext2: faddr = seg_q + AddrW'(2);
      SlFirst: faddr = '0;
      SlSec:   faddr = AddrW'(1);
      SlPen:   faddr = count_q[AddrW-1:0] - AddrW'(2);
      default: faddr = count_q[AddrW-1:0] - AddrW'(1);
    endcase
  end

  always_comb begin
    case (state_q)
      S_SCAN:  raddr = scan_q + AddrW'(1);
      S_FETCH: raddr = faddr;
      default: raddr = '0;
    endcase
  end

  // Tangents, doubled: closed paths wrap at both ends.
  assign closed    = slot_q[SlFirst].x == slot_q[SlLast].x &&
                     slot_q[SlFirst].y == slot_q[SlLast].y &&
                     slot_q[SlFirst].z == slot_q[SlLast].z;
  assign first_seg = seg_q == '0;
  assign last_seg  = ({1'b0, seg_q} + CntW'(2)) == count_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (first_seg) begin
        m1_d[a] = closed ? diff_t'(crd(slot_q[SlSec], 2'(a))) - crd(slot_q[SlPen], 2'(a))
                         : diff_t'(crd(slot_q[SlSec], 2'(a))) - crd(slot_q[SlFirst], 2'(a));
      end else begin
        m1_d[a] = diff_t'(crd(slot_q[SlNext], 2'(a))) - crd(slot_q[SlPrev], 2'(a));
      end
      if (last_seg) begin
        m2_d[a] = closed ? diff_t'(crd(slot_q[SlSec], 2'(a))) - crd(slot_q[SlPen], 2'(a))
                         : diff_t'(crd(slot_q[SlLast], 2'(a))) - crd(slot_q[SlPen], 2'(a));
      end else begin
        m2_d[a] = diff_t'(crd(slot_q[SlNext2], 2'(a))) - crd(slot_q[SlCur], 2'(a));
      end
    end
  end

  kcr_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  kcr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_w[31:0]),
    .den_i   (den_w[31:0]),
    .busy_o  (div_busy),
    .q_o     (t_w)
  );

  kcr_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ev_start),
    .t_i     (t_w),
    .p1_i    (slot_q[SlCur]),
    .p2_i    (slot_q[SlNext]),
    .m1_i    (m1_q),
    .m2_i    (m2_q),
    .done_o  (ev_done),
    .res_x_o (ev_x),
    .res_y_o (ev_y),
    .res_z_o (ev_z)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (!req_type_i || count_q == '0) ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_q == '0 && key_q < rdata.key) begin
          state_d = S_EMIT;
        end else if (found) begin
          state_d = S_FETCH;
        end else if (at_last) begin
          state_d = S_EMIT;
        end
      end
      S_FETCH: if (fetch_q == 4'd8) state_d = S_TAN;
      S_TAN:   if (!div_busy) state_d = S_EVAL;
      S_EVAL:  if (ev_done) state_d = S_EMIT;
      S_EMIT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        count_q <= count_q + CntW'(1);
      end
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        key_q  <= key_i;
        scan_q <= '0;
        res_x_q <= 32'sd0;
        res_y_q <= 32'sd0;
        res_z_q <= 32'sd0;
        if (!req_type_i) begin
          res_seg_q <= mem_we ? count_q[5:0] : 6'd0;
          res_st_q  <= mem_we ? StInsert : StFull;
        end else begin
          res_seg_q <= 6'd0;
          res_st_q  <= StEmpty;
        end
      end
      S_SCAN: begin
        prev_key_q <= rdata.key;
        scan_q     <= scan_q + AddrW'(1);
        fetch_q    <= 4'd0;
        seg_q      <= scan_q - AddrW'(1);
        res_x_q    <= rdata.x;
        res_y_q    <= rdata.y;
        res_z_q    <= rdata.z;
        res_seg_q  <= 6'(scan_q);
        res_st_q   <= StClamp;
      end
      S_FETCH: begin
        fetch_q <= fetch_q + 4'd1;
        if (fetch_q != 4'd0) begin
          slot_q[fetch_q[2:0] - 3'd1] <= rdata;
        end
      end
      S_TAN: begin
        m1_q <= m1_d;
        m2_q <= m2_d;
      end
      S_EVAL: begin
        if (ev_done) begin
          res_x_q   <= ev_x;
          res_y_q   <= ev_y;
          res_z_q   <= ev_z;
          res_seg_q <= 6'(seg_q);
          res_st_q  <= StInterp;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_x_o   <= res_x_q;
          out_y_o   <= res_y_q;
          out_z_o   <= res_z_q;
          segment_o <= res_seg_q;
          status_o  <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // The node count never passes the store depth.
  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxNodes))
    else $error("node count beyond store depth");

  // The count changes only through an accepted insert transaction.
  a_count_ins : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(in_acc && !req_type_i))
    else $error("node count changed without an insert");

  // The evaluator finishes only while the sequencer waits for it.
  a_eval_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_done |-> (state_q == S_EVAL))
    else $error("evaluation finished outside of a query");

  // A fresh result never carries an undefined status code.
  a_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (status_o <= StFull))
    else $error("illegal status code");

endmodule
